// ===== sv/attenuator_serial_command_writer_unit_assert.svh =====
// assertion macros used by the checker file of the attenuator command writer
// no dependencies; include by bare file name
`ifndef ATTENUATOR_SERIAL_COMMAND_WRITER_UNIT_ASSERT_SVH
`define ATTENUATOR_SERIAL_COMMAND_WRITER_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define ACSW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("acsw assertion failed");

// property checked at every clock edge, reset included
`define ACSW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("acsw assertion failed");

`endif

// ===== sv/acsw_pkg.sv =====
// types and constants of the attenuator serial command writer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package acsw_pkg;

   localparam int FRAME_BITS  = 11;
   localparam int PHASE_COUNT = 46;
   localparam int PHASE_W     = $clog2(PHASE_COUNT);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PHASE_W-1:0] PHASE_FIRST = '0;
   localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(PHASE_COUNT - 1);

   localparam logic [2:0] HOLD_IDLE = 3'd4;
   localparam logic [2:0] HOLD_BIT  = 3'd1;
   localparam logic [2:0] HOLD_END  = 3'd0;

   typedef logic [FRAME_BITS-1:0] frame_type;

   // one frame moving from the front end into the queue
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_xfer_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== sv/acsw_front.sv =====
// front end: takes a command, rejects bad channels, builds the 11-bit frame
// depends on acsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module acsw_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_func,
   input  wire logic [1:0]                 req_channel,
   input  wire logic signed [7:0]          req_att_db,
   input  wire acsw_pkg::queue_status_type q_status,
   output acsw_pkg::frame_xfer_type        push
);
   import acsw_pkg::*;

   typedef enum logic {
      FUNC_SINGLE = 1'b0,
      FUNC_BOTH   = 1'b1
   } func_type;

   localparam logic signed [7:0] DB_LOW    = -8'sd83;
   localparam logic [1:0]        PREAMBLE  = 2'b11;
   localparam logic [4:0]        ATT1_BASE = 5'd21;
   localparam logic [1:0]        CH_BOTH   = 2'b00;
   localparam logic              CH_SINGLE = 1'b1;
   localparam logic [1:0]        CHANNELS  = 2'd2;

   logic           valid_ff, valid_in;
   frame_type      frame_ff, frame_in;
   logic           accept;
   logic           cmd_ok;
   logic signed [8:0] neg_db;
   logic [6:0]     mag;
   logic [4:0]     att1;
   logic [1:0]     att2;
   logic [1:0]     ch_bits;

   assign busy   = reset | (valid_ff & q_status.full);
   assign accept = start & ~busy;

   always_comb begin
      // magnitude of the clamped dB value, 0..83
      neg_db = -{req_att_db[7], req_att_db};
      if (req_att_db < DB_LOW) begin
         mag = 7'd83;
      end else if (req_att_db > 8'sd0) begin
         mag = 7'd0;
      end else begin
         mag = neg_db[6:0];
      end
      att1 = ATT1_BASE - mag[6:2];
      att2 = 2'd3 - mag[1:0];
      unique case (func_type'(req_func))
         FUNC_SINGLE: begin
            cmd_ok  = (req_channel < CHANNELS);
            ch_bits = {CH_SINGLE, req_channel[0]};
         end
         FUNC_BOTH: begin
            cmd_ok  = 1'b1;
            ch_bits = CH_BOTH;
         end
         default: begin
            cmd_ok  = 1'b0;
            ch_bits = CH_BOTH;
         end
      endcase
      frame_in = {PREAMBLE, att2, att1, ch_bits};
   end

   // frame stays while the queue is full, rejected commands are dropped here
   assign valid_in = (valid_ff & q_status.full) | (accept & cmd_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         frame_ff <= frame_in;
      end
   end

   assign push.valid = valid_ff & ~q_status.full;
   assign push.frame = frame_ff;

endmodule

`default_nettype wire

// ===== sv/acsw_queue.sv =====
// two-entry frame queue between the front end and the phase sequencer
// depends on acsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module acsw_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire acsw_pkg::frame_xfer_type push,
   input  wire logic                    pop,
   output acsw_pkg::queue_status_type   status,
   output acsw_pkg::frame_type          head
);
   import acsw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push.valid & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

`default_nettype wire

// ===== sv/acsw_back.sv =====
// phase sequencer: plays one queued frame as 46 two-wire waveform phases
// depends on acsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module acsw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire acsw_pkg::queue_status_type q_status,
   input  wire acsw_pkg::frame_type        q_head,
   output logic                            pop,
   output logic                            rsp_strobe,
   output logic                            rsp_clock_level,
   output logic                            rsp_data_level,
   output logic [2:0]                      rsp_hold_quarters,
   output logic                            rsp_last
);
   import acsw_pkg::*;

   typedef enum logic [1:0] {
      SUB_CLK_HI_DATA = 2'd0,
      SUB_CLK_LO_DATA = 2'd1,
      SUB_CLK_LO_REST = 2'd2,
      SUB_CLK_HI_REST = 2'd3
   } sub_type;

   localparam int BIT_W = $clog2(FRAME_BITS);
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(FRAME_BITS - 1);

   logic               active_ff, active_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   frame_type          frame_ff, frame_in;
   logic [PHASE_W-1:0] bit_phase;
   logic [BIT_W-1:0]   bit_idx;
   logic               data_bit;
   logic               rest;
   logic               at_end;

   assign at_end = (phase_ff == PHASE_LAST);
   assign pop    = ~q_status.empty & (~active_ff | at_end);

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      frame_in  = frame_ff;
      if (pop) begin
         active_in = 1'b1;
         phase_in  = PHASE_FIRST;
         frame_in  = q_head;
      end else if (active_ff) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            phase_in = phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= PHASE_FIRST;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
      end
      frame_ff <= frame_in;
   end

   // four phases per frame bit after the leading idle phase
   always_comb begin
      bit_phase = phase_ff - 1'b1;
      bit_idx   = bit_phase[BIT_W+1:2];
      data_bit  = ~frame_ff[bit_idx];
      // the last bit releases data low instead of high
      rest      = (bit_idx != BIT_LAST);
      rsp_strobe        = active_ff;
      rsp_last          = active_ff & at_end;
      rsp_hold_quarters = HOLD_BIT;
      rsp_clock_level   = 1'b1;
      rsp_data_level    = 1'b1;
      if (phase_ff == PHASE_FIRST) begin
         rsp_hold_quarters = HOLD_IDLE;
      end else if (at_end) begin
         rsp_hold_quarters = HOLD_END;
      end else begin
         unique case (sub_type'(bit_phase[1:0]))
            SUB_CLK_HI_DATA: begin
               rsp_clock_level = 1'b1;
               rsp_data_level  = data_bit;
            end
            SUB_CLK_LO_DATA: begin
               rsp_clock_level = 1'b0;
               rsp_data_level  = data_bit;
            end
            SUB_CLK_LO_REST: begin
               rsp_clock_level = 1'b0;
               rsp_data_level  = rest;
            end
            SUB_CLK_HI_REST: begin
               rsp_clock_level = 1'b1;
               rsp_data_level  = rest;
            end
            default: begin
               rsp_clock_level = 1'b1;
               rsp_data_level  = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/attenuator_serial_command_writer_unit.sv =====
// top level of the attenuator serial command writer
// depends on acsw_pkg, acsw_front, acsw_queue, acsw_back
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low. Each valid command
// produces 46 waveform phases on the rsp_ ports, one per clock with rsp_strobe
// high and rsp_last on the final idle phase; the receiver cannot stall them, so
// they must be consumed as they appear. The phase sequencer emits one phase per
// cycle; frames of successive commands follow each other with no gap. With the
// sequencer idle and the queue empty, a command passes through the front
// register, a queue entry and the sequencer registers before its first phase is
// on the rsp_ ports. Up to three commands can be waiting (one in the front
// register, two in the queue) before busy rises. A single channel command with
// channel 2 or 3 is dropped in the front end and produces no phases.
module attenuator_serial_command_writer_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_func,
   input  wire logic [1:0]        req_channel,
   input  wire logic signed [7:0] req_att_db,
   output logic                   rsp_strobe,
   output logic                   rsp_clock_level,
   output logic                   rsp_data_level,
   output logic [2:0]             rsp_hold_quarters,
   output logic                   rsp_last
);
   import acsw_pkg::*;

   frame_xfer_type   push;
   queue_status_type q_status;
   frame_type        q_head;
   logic             pop;

   acsw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_func    (req_func),
      .req_channel (req_channel),
      .req_att_db  (req_att_db),
      .q_status    (q_status),
      .push        (push)
   );

   acsw_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (q_status),
      .head   (q_head)
   );

   acsw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_head            (q_head),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_clock_level   (rsp_clock_level),
      .rsp_data_level    (rsp_data_level),
      .rsp_hold_quarters (rsp_hold_quarters),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sv/acsw_checker.sv =====
// port-level checks for the attenuator serial command writer, bound to the top
// depends on attenuator_serial_command_writer_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "attenuator_serial_command_writer_unit_assert.svh"

module acsw_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic       rsp_clock_level,
   input wire logic       rsp_data_level,
   input wire logic [2:0] rsp_hold_quarters,
   input wire logic       rsp_last
);

   // nothing comes out in the cycle after reset
   `ACSW_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_strobe)

   // no command is taken while reset is high
   `ACSW_ASSERT_ALWAYS(a_busy_in_reset, clock, reset |-> busy)

   // a frame never breaks off before its final phase
   `ACSW_ASSERT(a_frame_contiguous, clock, reset, rsp_strobe && !rsp_last |=> rsp_strobe)

   // the final phase is the released idle level with no hold
   `ACSW_ASSERT(a_last_idle, clock, reset,
      rsp_last |-> rsp_strobe && rsp_clock_level && rsp_data_level
                   && rsp_hold_quarters == 3'd0)

   // the leading idle phase is followed by the first bit with clock high
   `ACSW_ASSERT(a_lead_then_bit, clock, reset,
      rsp_strobe && rsp_hold_quarters == 3'd4
      |=> rsp_strobe && rsp_clock_level && rsp_hold_quarters == 3'd1)

endmodule

bind attenuator_serial_command_writer_unit acsw_port_checker u_acsw_port_checker (
   .clock             (clock),
   .reset             (reset),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_clock_level   (rsp_clock_level),
   .rsp_data_level    (rsp_data_level),
   .rsp_hold_quarters (rsp_hold_quarters),
   .rsp_last          (rsp_last)
);

`default_nettype wire
